// ===== sv/lfpd_pkg.sv =====
// shared types, constants and micro-op codes of the line follower drive
`default_nettype none
package lfpd_pkg;

    localparam int E_W   = 5;
    localparam int D_W   = 6;
    localparam int ACC_W = 22;
    localparam int G_W   = 29;
    localparam int PC_W  = 5;
    localparam int OP_W  = 4;
    localparam int CND_W = 3;
    localparam int HOLD_W = 10;
    localparam int CNT_W = 5;

    localparam logic signed [E_W-1:0] E_CENTER = 5'sd0;
    localparam logic signed [E_W-1:0] E_LEFT   = 5'sd10;
    localparam logic signed [E_W-1:0] E_RIGHT  = -5'sd10;
    localparam logic signed [E_W-1:0] E_LOST_L = 5'sd12;
    localparam logic signed [E_W-1:0] E_LOST_R = -5'sd12;

    localparam logic [CNT_W-1:0] SLOPE_STEPS = 5'd12;

    // ceil(2^32 / 10), exact floor division by ten for values below 2^30
    localparam logic [28:0] SPD_RECIP = 29'd429496730;

    // micro-ops
    localparam logic [OP_W-1:0] OP_NOP        = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD       = 4'd1;
    localparam logic [OP_W-1:0] OP_IMUL       = 4'd2;
    localparam logic [OP_W-1:0] OP_IADD       = 4'd3;
    localparam logic [OP_W-1:0] OP_ICLAMP     = 4'd4;
    localparam logic [OP_W-1:0] OP_PMUL       = 4'd5;
    localparam logic [OP_W-1:0] OP_GLOAD      = 4'd6;
    localparam logic [OP_W-1:0] OP_SDIV_INIT  = 4'd7;
    localparam logic [OP_W-1:0] OP_DIV_STEP   = 4'd8;
    localparam logic [OP_W-1:0] OP_DMUL       = 4'd9;
    localparam logic [OP_W-1:0] OP_DSCALE     = 4'd10;
    localparam logic [OP_W-1:0] OP_GADD       = 4'd11;
    localparam logic [OP_W-1:0] OP_SPEED      = 4'd12;
    localparam logic [OP_W-1:0] OP_MAG        = 4'd13;
    localparam logic [OP_W-1:0] OP_EMIT_DRIVE = 4'd14;
    localparam logic [OP_W-1:0] OP_EMIT_STOP  = 4'd15;

    // jump conditions
    localparam logic [CND_W-1:0] C_NEVER      = 3'd0;
    localparam logic [CND_W-1:0] C_ALWAYS     = 3'd1;
    localparam logic [CND_W-1:0] C_NO_REQ     = 3'd2;
    localparam logic [CND_W-1:0] C_SLOPE_ZERO = 3'd3;
    localparam logic [CND_W-1:0] C_DIV_MORE   = 3'd4;
    localparam logic [CND_W-1:0] C_OUT_BUSY   = 3'd5;
    localparam logic [CND_W-1:0] C_NO_PIVOT   = 3'd6;

    // configuration register indexes
    localparam logic [2:0] R_PROP_GAIN     = 3'd0;
    localparam logic [2:0] R_INTEG_GAIN    = 3'd1;
    localparam logic [2:0] R_DERIV_GAIN    = 3'd2;
    localparam logic [2:0] R_INTEG_LIMIT   = 3'd3;
    localparam logic [2:0] R_BASE_DRIVE    = 3'd4;
    localparam logic [2:0] R_SINGLE_DRIVE  = 3'd5;
    localparam logic [2:0] R_DUTY_OFFSET   = 3'd6;
    localparam logic [2:0] R_PIVOT_HOLD_MS = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [CND_W-1:0] cond;
        logic [PC_W-1:0]  target;
    } ctl_t;

    typedef struct packed {
        logic no_req;
        logic slope_zero;
        logic div_more;
        logic out_busy;
        logic no_pivot;
    } stat_t;

    typedef struct packed {
        logic [11:0]       prop_gain;
        logic [11:0]       integ_gain;
        logic [11:0]       deriv_gain;
        logic [15:0]       integ_limit;
        logic [11:0]       base_drive;
        logic [11:0]       single_drive;
        logic [11:0]       duty_offset;
        logic [HOLD_W-1:0] pivot_hold_ms;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        prop_gain:     12'd300,
        integ_gain:    12'd0,
        deriv_gain:    12'd170,
        integ_limit:   16'd1000,
        base_drive:    12'd1260,
        single_drive:  12'd1425,
        duty_offset:   12'd1250,
        pivot_hold_ms: 10'd150
    };

endpackage
`default_nettype wire

// ===== sv/lfpd_if.sv =====
// sensor request and drive result channel interfaces
`default_nettype none
interface lfpd_in_if;
    logic        valid;
    logic        ready;
    logic        left_on_tape;
    logic        right_on_tape;
    logic [31:0] now_ms;

    modport source (output valid, left_on_tape, right_on_tape, now_ms, input ready);
    modport sink (input valid, left_on_tape, right_on_tape, now_ms, output ready);
endinterface

interface lfpd_out_if #(
    parameter int DUTY_BITS = 12
);
    logic                 valid;
    logic                 ready;
    logic [DUTY_BITS-1:0] right_fwd_duty;
    logic [DUTY_BITS-1:0] right_back_duty;
    logic [DUTY_BITS-1:0] left_fwd_duty;
    logic [DUTY_BITS-1:0] left_back_duty;
    logic [9:0]           hold_time_ms;
    logic                 last_of_run;

    modport source (
        output valid, right_fwd_duty, right_back_duty, left_fwd_duty, left_back_duty,
        output hold_time_ms, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, right_fwd_duty, right_back_duty, left_fwd_duty, left_back_duty,
        input  hold_time_ms, last_of_run,
        output ready
    );
endinterface
`default_nettype wire

// ===== sv/lfpd_seq.sv =====
// microcode sequencer: step counter, control store and conditional jumps
`default_nettype none
module lfpd_seq
    import lfpd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire stat_t stat,
    output ctl_t       ctl
);

    localparam logic [PC_W-1:0] P_WAIT      = 5'd0;
    localparam logic [PC_W-1:0] P_SDIV_LOOP = 5'd8;
    localparam logic [PC_W-1:0] P_SPEED     = 5'd12;
    localparam logic [PC_W-1:0] P_EMIT      = 5'd14;
    localparam logic [PC_W-1:0] P_STOP      = 5'd16;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            take;

    // control store
    always_comb
    begin
        case (pc_reg)
            5'd0:    ctl = '{OP_LOAD,       C_NO_REQ,     P_WAIT};
            5'd1:    ctl = '{OP_IMUL,       C_NEVER,      P_WAIT};
            5'd2:    ctl = '{OP_IADD,       C_NEVER,      P_WAIT};
            5'd3:    ctl = '{OP_ICLAMP,     C_NEVER,      P_WAIT};
            5'd4:    ctl = '{OP_PMUL,       C_NEVER,      P_WAIT};
            5'd5:    ctl = '{OP_GLOAD,      C_NEVER,      P_WAIT};
            5'd6:    ctl = '{OP_NOP,        C_SLOPE_ZERO, P_SPEED};
            5'd7:    ctl = '{OP_SDIV_INIT,  C_NEVER,      P_WAIT};
            5'd8:    ctl = '{OP_DIV_STEP,   C_DIV_MORE,   P_SDIV_LOOP};
            5'd9:    ctl = '{OP_DMUL,       C_NEVER,      P_WAIT};
            5'd10:   ctl = '{OP_DSCALE,     C_NEVER,      P_WAIT};
            5'd11:   ctl = '{OP_GADD,       C_NEVER,      P_WAIT};
            5'd12:   ctl = '{OP_SPEED,      C_NEVER,      P_WAIT};
            5'd13:   ctl = '{OP_MAG,        C_NEVER,      P_WAIT};
            5'd14:   ctl = '{OP_EMIT_DRIVE, C_OUT_BUSY,   P_EMIT};
            5'd15:   ctl = '{OP_NOP,        C_NO_PIVOT,   P_WAIT};
            5'd16:   ctl = '{OP_EMIT_STOP,  C_OUT_BUSY,   P_STOP};
            5'd17:   ctl = '{OP_NOP,        C_ALWAYS,     P_WAIT};
            default: ctl = '{OP_NOP,        C_ALWAYS,     P_WAIT};
        endcase
    end

    always_comb
    begin
        case (ctl.cond)
            C_NEVER:      take = 1'b0;
            C_ALWAYS:     take = 1'b1;
            C_NO_REQ:     take = stat.no_req;
            C_SLOPE_ZERO: take = stat.slope_zero;
            C_DIV_MORE:   take = stat.div_more;
            C_OUT_BUSY:   take = stat.out_busy;
            C_NO_PIVOT:   take = stat.no_pivot;
            default:      take = 1'b1;
        endcase
        pc_next = take ? ctl.target : pc_reg + 5'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= P_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/lfpd_dpath.sv =====
// datapath: error and timing state, pid terms, serial slope divider, result register
`default_nettype none
module lfpd_dpath
    import lfpd_pkg::*;
#(
    parameter int STOP_HOLD_MS = 50,
    parameter int DUTY_BITS    = 12
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire ctl_t  ctl,
    input  wire cfg_t  cfg,
    output stat_t      stat,
    lfpd_in_if.sink    in_ch,
    lfpd_out_if.source out_ch
);

    localparam logic [25:0] DUTY_MAX = 26'((1 << DUTY_BITS) - 1);
    localparam logic [HOLD_W-1:0] STOP_HOLD = HOLD_W'(STOP_HOLD_MS);

    // loop state
    logic                    side_left_reg;
    logic signed [E_W-1:0]   prev_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [31:0]             start_reg;
    logic [31:0]             mid_reg;
    logic [31:0]             steady_reg;

    // per-request working registers
    logic signed [E_W-1:0]   e_reg;
    logic signed [D_W-1:0]   diff_reg;
    logic                    chg_reg;
    logic [31:0]             dt_reg;
    logic signed [G_W-1:0]   mul_reg;
    logic signed [G_W-1:0]   g_reg;
    logic [24:0]             mag_reg;

    // serial divider
    logic [30:0]             rem_reg;
    logic [27:0]             dvd_reg;
    logic [30:0]             dsr_reg;
    logic [CNT_W-1:0]        cnt_reg;

    // result register
    logic                    out_valid_reg;
    logic [DUTY_BITS-1:0]    rf_reg;
    logic [DUTY_BITS-1:0]    rb_reg;
    logic [DUTY_BITS-1:0]    lf_reg;
    logic [DUTY_BITS-1:0]    lb_reg;
    logic [HOLD_W-1:0]       hold_reg;
    logic                    last_reg;

    logic signed [E_W-1:0]   e_next;
    logic                    side_left_next;
    logic                    accept;
    logic                    out_free;
    logic                    pivot;
    logic                    g_zero;
    logic                    g_neg;
    logic [11:0]             gain_sel;
    logic signed [17:0]      small_prod;
    logic [23:0]             d_prod;
    logic [19:0]             lim20;
    logic signed [ACC_W-1:0] lim;
    logic [D_W-1:0]          diff_abs;
    logic [11:0]             slope_num;
    logic [G_W-1:0]          g_abs;
    logic [56:0]             spd_prod;
    logic [31:0]             div_shift;
    logic [31:0]             div_trial;
    logic                    div_bit;
    logic [25:0]             duty_sum;
    logic [DUTY_BITS-1:0]    duty;

    // error from the sensors
    always_comb
    begin
        side_left_next = side_left_reg;
        if (in_ch.left_on_tape && in_ch.right_on_tape)
        begin
            e_next = E_CENTER;
        end
        else if (in_ch.left_on_tape)
        begin
            e_next         = E_LEFT;
            side_left_next = 1'b1;
        end
        else if (in_ch.right_on_tape)
        begin
            e_next         = E_RIGHT;
            side_left_next = 1'b0;
        end
        else
        begin
            e_next = side_left_reg ? E_LOST_L : E_LOST_R;
        end
    end

    assign in_ch.ready = (ctl.op == OP_LOAD);
    assign accept      = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign pivot       = (e_reg == E_LOST_L) || (e_reg == E_LOST_R);
    assign g_zero      = (g_reg == '0);
    assign g_neg       = g_reg[G_W-1];

    always_comb
    begin
        gain_sel   = (ctl.op == OP_PMUL) ? cfg.prop_gain : cfg.integ_gain;
        small_prod = $signed({1'b0, gain_sel}) * e_reg;
        d_prod     = cfg.deriv_gain * dvd_reg[11:0];
        lim20      = ({4'b0, cfg.integ_limit} << 3) + ({4'b0, cfg.integ_limit} << 1);
        lim        = $signed({2'b0, lim20});
        diff_abs   = diff_reg[D_W-1] ? D_W'(-diff_reg) : D_W'(diff_reg);
        slope_num  = ({6'b0, diff_abs} << 6) + ({6'b0, diff_abs} << 5)
                   + ({6'b0, diff_abs} << 2);
        g_abs      = g_neg ? G_W'(-g_reg) : G_W'(g_reg);
        // speed = |g| / 10 by reciprocal multiplication
        spd_prod   = g_abs[27:0] * SPD_RECIP;
        div_shift  = {rem_reg, dvd_reg[27]};
        div_trial  = div_shift - {1'b0, dsr_reg};
        div_bit    = (div_shift >= {1'b0, dsr_reg});
        duty_sum   = {1'b0, mag_reg} + {14'b0, cfg.duty_offset};
        if (mag_reg == '0)
        begin
            duty = '0;
        end
        else if (duty_sum > DUTY_MAX)
        begin
            duty = {DUTY_BITS{1'b1}};
        end
        else
        begin
            duty = duty_sum[DUTY_BITS-1:0];
        end
    end

    always_comb
    begin
        stat.no_req     = !in_ch.valid;
        stat.slope_zero = !chg_reg || dt_reg[31] || (dt_reg == '0);
        stat.div_more   = (cnt_reg != 5'd1);
        stat.out_busy   = !out_free;
        stat.no_pivot   = g_zero || !pivot;
    end

    // loop state and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_left_reg <= 1'b0;
            prev_reg      <= E_CENTER;
            acc_reg       <= '0;
            start_reg     <= '0;
            mid_reg       <= '0;
            steady_reg    <= '0;
            chg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                side_left_reg <= side_left_next;
                prev_reg      <= e_next;
                chg_reg       <= (e_next != prev_reg);
                if (e_next == prev_reg)
                begin
                    steady_reg <= in_ch.now_ms;
                end
                else
                begin
                    start_reg <= mid_reg;
                    mid_reg   <= in_ch.now_ms;
                end
            end
            case (ctl.op)
                OP_IADD:
                begin
                    acc_reg <= acc_reg + $signed(mul_reg[ACC_W-1:0]);
                end
                OP_ICLAMP:
                begin
                    if (acc_reg > lim)
                    begin
                        acc_reg <= lim;
                    end
                    else if (acc_reg < -lim)
                    begin
                        acc_reg <= -lim;
                    end
                end
                default:
                begin
                end
            endcase
            if (((ctl.op == OP_EMIT_DRIVE) || (ctl.op == OP_EMIT_STOP)) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working registers, divider and result payload
    always_ff @(posedge clk)
    begin
        case (ctl.op)
            OP_LOAD:
            begin
                if (accept)
                begin
                    e_reg    <= e_next;
                    diff_reg <= {e_next[E_W-1], e_next} - {prev_reg[E_W-1], prev_reg};
                    dt_reg   <= steady_reg - mid_reg;
                end
            end
            OP_IMUL, OP_PMUL:
            begin
                mul_reg <= G_W'(small_prod);
            end
            OP_GLOAD:
            begin
                g_reg <= G_W'(acc_reg) + mul_reg;
            end
            OP_SDIV_INIT:
            begin
                rem_reg <= '0;
                dvd_reg <= {slope_num, 16'b0};
                dsr_reg <= dt_reg[30:0];
                cnt_reg <= SLOPE_STEPS;
            end
            OP_SPEED:
            begin
                dvd_reg <= {3'b0, spd_prod[56:32]};
            end
            OP_DIV_STEP:
            begin
                rem_reg <= div_bit ? div_trial[30:0] : div_shift[30:0];
                dvd_reg <= {dvd_reg[26:0], div_bit};
                cnt_reg <= cnt_reg - 5'd1;
            end
            OP_DMUL:
            begin
                mul_reg <= {{(G_W-24){1'b0}}, d_prod};
            end
            OP_DSCALE:
            begin
                mul_reg <= (mul_reg <<< 3) + (mul_reg <<< 1);
            end
            OP_GADD:
            begin
                g_reg <= diff_reg[D_W-1] ? g_reg - mul_reg : g_reg + mul_reg;
            end
            OP_MAG:
            begin
                mag_reg <= {13'b0, ((g_zero || pivot) ? cfg.base_drive : cfg.single_drive)}
                         + {1'b0, dvd_reg[23:0]};
            end
            OP_EMIT_DRIVE:
            begin
                if (out_free)
                begin
                    if (g_zero)
                    begin
                        rf_reg   <= duty;
                        rb_reg   <= '0;
                        lf_reg   <= duty;
                        lb_reg   <= '0;
                        hold_reg <= '0;
                        last_reg <= 1'b1;
                    end
                    else if (pivot)
                    begin
                        rf_reg   <= '0;
                        rb_reg   <= g_neg ? '0 : duty;
                        lf_reg   <= '0;
                        lb_reg   <= g_neg ? duty : '0;
                        hold_reg <= cfg.pivot_hold_ms;
                        last_reg <= 1'b0;
                    end
                    else
                    begin
                        rf_reg   <= g_neg ? duty : '0;
                        rb_reg   <= '0;
                        lf_reg   <= g_neg ? '0 : duty;
                        lb_reg   <= '0;
                        hold_reg <= '0;
                        last_reg <= 1'b1;
                    end
                end
            end
            OP_EMIT_STOP:
            begin
                if (out_free)
                begin
                    rf_reg   <= '0;
                    rb_reg   <= '0;
                    lf_reg   <= '0;
                    lb_reg   <= '0;
                    hold_reg <= STOP_HOLD;
                    last_reg <= 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.right_fwd_duty  = rf_reg;
    assign out_ch.right_back_duty = rb_reg;
    assign out_ch.left_fwd_duty   = lf_reg;
    assign out_ch.left_back_duty  = lb_reg;
    assign out_ch.hold_time_ms    = hold_reg;
    assign out_ch.last_of_run     = last_reg;

endmodule
`default_nettype wire

// ===== sv/line_follower_pid_drive.sv =====
// top level of the two-sensor pid line follower drive stage
//
// in_ch takes one sensor request per item: the two reflectance bits and a
// millisecond timestamp. out_ch gives the motor duty results of each request:
// one result for straight or one-sided drive, two for a pivot (the timed
// reverse result, then the timed stop result flagged last_of_run).
// cfg_we/cfg_index/cfg_data write the eight gain and drive registers.
// a microcoded sequencer walks each request through a small datapath; a
// request is taken only at the first step of the program, so requests are
// handled one at a time. the 12-step serial slope divider runs only when
// the error changed over a positive interval and is skipped when the slope
// is zero; the division by ten is a reciprocal multiply.
// results leave through a result register, so the next request is accepted
// while the last result waits; a stalled receiver holds the program at its
// emit step. reset restores the register defaults, clears the tracking state
// and empties the result register.
`default_nettype none
module line_follower_pid_drive
    import lfpd_pkg::*;
#(
    parameter int STOP_HOLD_MS = 50,
    parameter int DUTY_BITS    = 12
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    lfpd_in_if.sink          in_ch,
    lfpd_out_if.source       out_ch,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    cfg_t  cfg_reg;
    ctl_t  ctl;
    stat_t stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                R_PROP_GAIN:     cfg_reg.prop_gain     <= cfg_data[11:0];
                R_INTEG_GAIN:    cfg_reg.integ_gain    <= cfg_data[11:0];
                R_DERIV_GAIN:    cfg_reg.deriv_gain    <= cfg_data[11:0];
                R_INTEG_LIMIT:   cfg_reg.integ_limit   <= cfg_data;
                R_BASE_DRIVE:    cfg_reg.base_drive    <= cfg_data[11:0];
                R_SINGLE_DRIVE:  cfg_reg.single_drive  <= cfg_data[11:0];
                R_DUTY_OFFSET:   cfg_reg.duty_offset   <= cfg_data[11:0];
                R_PIVOT_HOLD_MS: cfg_reg.pivot_hold_ms <= cfg_data[HOLD_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    lfpd_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    lfpd_dpath #(
        .STOP_HOLD_MS (STOP_HOLD_MS),
        .DUTY_BITS    (DUTY_BITS)
    ) u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .cfg    (cfg_reg),
        .stat   (stat),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// testbench for the line follower pid drive stage: predicted motor duties checked per result
`timescale 1ns / 100ps
module tb
    import lfpd_pkg::*;
();

    localparam int DUTY_BITS      = 12;
    localparam int STOP_HOLD_MS   = 50;
    localparam longint DUTY_MAX   = (64'd1 << DUTY_BITS) - 1;
    localparam int SETTLE_CYCLES  = 80;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_OFF_LEN   = 600;
    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 75;

    typedef struct packed {
        logic        left_on_tape;
        logic        right_on_tape;
        logic [31:0] now_ms;
    } sensor_req_t;

    typedef struct packed {
        logic [DUTY_BITS-1:0] right_fwd;
        logic [DUTY_BITS-1:0] right_back;
        logic [DUTY_BITS-1:0] left_fwd;
        logic [DUTY_BITS-1:0] left_back;
        logic [HOLD_W-1:0]    hold_ms;
        logic                 last_of_run;
    } drive_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    lfpd_in_if in_ch ();
    lfpd_out_if #(.DUTY_BITS(DUTY_BITS)) out_ch ();

    line_follower_pid_drive #(
        .STOP_HOLD_MS(STOP_HOLD_MS),
        .DUTY_BITS(DUTY_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    sensor_req_t sensor_reqs[$];
    drive_t      expected_drive[$];
    int          errors = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic        hold_off_go = 1'b0;
    int          hold_left = 0;
    int          quiet_cycles = 0;
    logic [31:0] ms_clock = 32'd0;

    // tracking state of the drive stage
    cfg_t        ctrl = CFG_RESET;
    logic        seen_left = 1'b0;
    int          prev_err = 0;
    longint      integ_acc = 0;
    logic [31:0] chg_start = 32'd0;
    logic [31:0] chg_mid = 32'd0;
    logic [31:0] steady_end = 32'd0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [DUTY_BITS-1:0] duty_for(input longint mag);
        longint d;
        if (mag <= 0)
            return '0;
        d = mag + longint'(ctrl.duty_offset);
        if (d > DUTY_MAX)
            d = DUTY_MAX;
        return d[DUTY_BITS-1:0];
    endfunction

    function automatic drive_t make_drive(input longint right, input longint left,
                                          input logic [HOLD_W-1:0] hold, input logic last);
        drive_t d;
        d.right_fwd   = right > 0 ? duty_for(right) : '0;
        d.right_back  = right < 0 ? duty_for(-right) : '0;
        d.left_fwd    = left > 0 ? duty_for(left) : '0;
        d.left_back   = left < 0 ? duty_for(-left) : '0;
        d.hold_ms     = hold;
        d.last_of_run = last;
        return d;
    endfunction

    function automatic void predict_drive(input logic l, input logic r, input logic [31:0] now);
        int     err;
        int     dt;
        longint slope;
        longint lim;
        longint g;
        longint speed;
        longint rev;
        if (l && r)
            err = E_CENTER;
        else if (l)
        begin
            seen_left = 1'b1;
            err = E_LEFT;
        end
        else if (r)
        begin
            seen_left = 1'b0;
            err = E_RIGHT;
        end
        else
            err = seen_left ? E_LOST_L : E_LOST_R;

        slope = 0;
        if (err == prev_err)
            steady_end = now;
        else
        begin
            chg_start = chg_mid;
            chg_mid = now;
            dt = int'(steady_end - chg_start);
            if (dt > 0)
                slope = (longint'(err - prev_err) * 100) / longint'(dt);
        end

        lim = longint'(ctrl.integ_limit) * 10;
        integ_acc += longint'(ctrl.integ_gain) * err;
        if (integ_acc > lim)
            integ_acc = lim;
        else if (integ_acc < -lim)
            integ_acc = -lim;

        g = longint'(ctrl.prop_gain) * err + integ_acc + longint'(ctrl.deriv_gain) * slope * 10;
        speed = (g < 0 ? -g : g) / 10;
        prev_err = err;

        if (g == 0)
            expected_drive.push_back(make_drive(ctrl.base_drive, ctrl.base_drive, '0, 1'b1));
        else if (err > E_LEFT || err < E_RIGHT)
        begin
            rev = -(longint'(ctrl.base_drive) + speed);
            if (g < 0)
                expected_drive.push_back(make_drive(0, rev, ctrl.pivot_hold_ms, 1'b0));
            else
                expected_drive.push_back(make_drive(rev, 0, ctrl.pivot_hold_ms, 1'b0));
            expected_drive.push_back(make_drive(0, 0, HOLD_W'(STOP_HOLD_MS), 1'b1));
        end
        else if (g < 0)
            expected_drive.push_back(make_drive(longint'(ctrl.single_drive) + speed, 0, '0, 1'b1));
        else
            expected_drive.push_back(make_drive(0, longint'(ctrl.single_drive) + speed, '0, 1'b1));
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // request driver
    always @(posedge clk)
    begin
        sensor_req_t nxt;
        if (!rst_n)
        begin
            in_ch.valid         <= 1'b0;
            in_ch.left_on_tape  <= 1'b0;
            in_ch.right_on_tape <= 1'b0;
            in_ch.now_ms        <= 32'd0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                predict_drive(in_ch.left_on_tape, in_ch.right_on_tape, in_ch.now_ms);
            if (!in_ch.valid || in_ch.ready)
            begin
                if (sensor_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = sensor_reqs.pop_front();
                    in_ch.valid         <= 1'b1;
                    in_ch.left_on_tape  <= nxt.left_on_tape;
                    in_ch.right_on_tape <= nxt.right_on_tape;
                    in_ch.now_ms        <= nxt.now_ms;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk)
    begin
        drive_t got;
        drive_t want;
        if (out_ch.valid && out_ch.ready)
        begin
            got = '{out_ch.right_fwd_duty, out_ch.right_back_duty, out_ch.left_fwd_duty,
                    out_ch.left_back_duty, out_ch.hold_time_ms, out_ch.last_of_run};
            if (expected_drive.size() == 0)
            begin
                $error("drive result with none expected");
                errors++;
            end
            else
            begin
                want = expected_drive.pop_front();
                check_field("right_fwd_duty", want.right_fwd, got.right_fwd);
                check_field("right_back_duty", want.right_back, got.right_back);
                check_field("left_fwd_duty", want.left_fwd, got.left_fwd);
                check_field("left_back_duty", want.left_back, got.left_back);
                check_field("hold_time_ms", want.hold_ms, got.hold_ms);
                check_field("last_of_run", want.last_of_run, got.last_of_run);
            end
        end
        if (hold_left != 0)
        begin
            out_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_off_go)
        begin
            out_ch.ready <= 1'b0;
            hold_left <= HOLD_OFF_LEN;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic queue_item(input logic l, input logic r, input logic [31:0] now);
        sensor_reqs.push_back('{l, r, now});
    endtask

    // runs of steady readings with advancing time, plus jumps and random noise
    task automatic queue_random(input int count);
        int   left_n;
        int   run_len;
        logic l;
        logic r;
        left_n = count;
        while (left_n > 0)
        begin
            l = 1'($urandom_range(1));
            r = 1'($urandom_range(1));
            if ($urandom_range(9) == 0)
            begin
                if ($urandom_range(1))
                    ms_clock = $urandom();
                else
                    ms_clock = ms_clock - $urandom_range(1, 200);
                queue_item(l, r, ms_clock);
                left_n--;
            end
            else
            begin
                run_len = $urandom_range(1, 6);
                while (run_len > 0 && left_n > 0)
                begin
                    ms_clock = ms_clock + $urandom_range(0, 30);
                    queue_item(l, r, ms_clock);
                    run_len--;
                    left_n--;
                end
            end
        end
    endtask

    task automatic drain();
        while (sensor_reqs.size() != 0 || in_ch.valid || expected_drive.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
    endtask

    task automatic apply_config(input cfg_t c);
        write_reg(R_PROP_GAIN, 16'(c.prop_gain));
        write_reg(R_INTEG_GAIN, 16'(c.integ_gain));
        write_reg(R_DERIV_GAIN, 16'(c.deriv_gain));
        write_reg(R_INTEG_LIMIT, c.integ_limit);
        write_reg(R_BASE_DRIVE, 16'(c.base_drive));
        write_reg(R_SINGLE_DRIVE, 16'(c.single_drive));
        write_reg(R_DUTY_OFFSET, 16'(c.duty_offset));
        write_reg(R_PIVOT_HOLD_MS, 16'(c.pivot_hold_ms));
        @(posedge clk);
        cfg_we <= 1'b0;
        ctrl = c;
    endtask

    function automatic cfg_t random_config();
        cfg_t c;
        c.prop_gain     = 12'($urandom_range(0, 4095));
        c.integ_gain    = $urandom_range(1) ? 12'($urandom_range(0, 4095))
                                            : 12'($urandom_range(0, 20));
        c.deriv_gain    = 12'($urandom_range(0, 4095));
        c.integ_limit   = $urandom_range(1) ? 16'($urandom_range(0, 65535))
                                            : 16'($urandom_range(0, 300));
        c.base_drive    = 12'($urandom_range(0, 4095));
        c.single_drive  = 12'($urandom_range(0, 4095));
        c.duty_offset   = 12'($urandom_range(0, 4095));
        c.pivot_hold_ms = 10'($urandom_range(0, 1023));
        return c;
    endfunction

    initial
    begin
        cfg_t c;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= R_PROP_GAIN;
        cfg_data  <= 16'd0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: straight, one-sided, pivots both ways, flat and backward time
        @(negedge clk);
        queue_item(1'b1, 1'b1, 32'd0);
        queue_item(1'b1, 1'b1, 32'd100);
        queue_item(1'b1, 1'b0, 32'd150);
        queue_item(1'b1, 1'b0, 32'd200);
        queue_item(1'b0, 1'b0, 32'd260);
        queue_item(1'b0, 1'b0, 32'd300);
        queue_item(1'b0, 1'b1, 32'd340);
        queue_item(1'b0, 1'b0, 32'd380);
        queue_item(1'b0, 1'b1, 32'd380);
        queue_item(1'b0, 1'b1, 32'd380);
        queue_item(1'b1, 1'b0, 32'd380);
        queue_item(1'b1, 1'b0, 32'd100);
        queue_item(1'b0, 1'b1, 32'd50);
        queue_item(1'b1, 1'b1, 32'hFFFF_FFFF);
        queue_item(1'b1, 1'b0, 32'd0);
        queue_item(1'b1, 1'b1, 32'hFFFF_FFFF);
        queue_item(1'b0, 1'b0, 32'h8000_0000);
        queue_item(1'b0, 1'b0, 32'h8000_0001);
        queue_item(1'b0, 1'b1, 32'h7FFF_FFFF);
        queue_item(1'b1, 1'b1, 32'd5);
        queue_item(1'b1, 1'b1, 32'd9);

        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            case (p)
                0: c = '{12'd4095, 12'd4095, 12'd4095, 16'd65535,
                         12'd4095, 12'd4095, 12'd4095, 10'd1023};
                1: c = '0;
                // small gains: only the integral term acts, and the pid sum stays within +/-50
                2: c = '{12'd0, 12'd1, 12'd0, 16'd5, 12'd7, 12'd3, 12'd0, 10'd1};
                default: c = random_config();
            endcase
            apply_config(c);
            @(negedge clk);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            queue_random(PHASE_ITEMS);
            if (p == 4)
            begin
                hold_off_go = 1'b1;
                @(negedge clk);
                hold_off_go = 1'b0;
            end
        end

        drain();
        if (errors == 0 && expected_drive.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
